// ===== rtl/clbc_pkg.sv =====
// Shared types, codes and helpers for the character LCD bus controller.
package clbc_pkg;

  localparam int COUNT_WIDTH_DEF = 10;
  localparam int CFG_DATA_W      = 10;
  localparam int CFG_IDX_W       = 3;
  localparam int QUEUE_DEPTH     = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FOUR_BIT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETUP       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ADDR_INCR   = 3'd4;

  localparam logic [CFG_DATA_W-1:0] SETUP_RST       = 10'd3;
  localparam logic [CFG_DATA_W-1:0] ENABLE_HIGH_RST = 10'd23;
  localparam logic [CFG_DATA_W-1:0] ENABLE_LOW_RST  = 10'd28;
  localparam logic [CFG_DATA_W-1:0] ADDR_INCR_RST   = 10'd200;

  // request modes
  localparam logic [3:0] MODE_TICK    = 4'd0;
  localparam logic [3:0] MODE_CLEAR   = 4'd1;
  localparam logic [3:0] MODE_HOME    = 4'd2;
  localparam logic [3:0] MODE_ENTRY   = 4'd3;
  localparam logic [3:0] MODE_ONOFF   = 4'd4;
  localparam logic [3:0] MODE_SHIFT   = 4'd5;
  localparam logic [3:0] MODE_FUNCSET = 4'd6;
  localparam logic [3:0] MODE_CGADDR  = 4'd7;
  localparam logic [3:0] MODE_DDADDR  = 4'd8;
  localparam logic [3:0] MODE_WRDATA  = 4'd9;
  localparam logic [3:0] MODE_RDADDR  = 4'd10;
  localparam logic [3:0] MODE_RDDATA  = 4'd11;
  localparam logic [3:0] MODE_RAW     = 4'd12;

  typedef struct packed {
    logic       start;    // item carries a request
    logic [3:0] kind;
    logic [7:0] pbyte;    // instruction or data byte to put on the bus
    logic       polling;  // request polls busy first
    logic [7:0] bus;      // sampled LCD pins this tick
  } req_t;

  typedef struct packed {
    logic                  four_bit;
    logic [CFG_DATA_W-1:0] setup;
    logic [CFG_DATA_W-1:0] enable_high;
    logic [CFG_DATA_W-1:0] enable_low;
    logic [CFG_DATA_W-1:0] addr_incr;
  } cfg_t;

  function automatic logic [7:0] form_byte(input logic [3:0] kind, input logic [7:0] b);
    logic [7:0] r;
    r = 8'h00;
    case (kind)
      MODE_CLEAR:   r = 8'h01;
      MODE_HOME:    r = 8'h02;
      MODE_ENTRY:   r = 8'h04 | (b & 8'h03);
      MODE_ONOFF:   r = 8'h08 | (b & 8'h07);
      MODE_SHIFT:   r = 8'h10 | (b & 8'h0c);
      MODE_FUNCSET: r = 8'h20 | (b & 8'h1c);
      MODE_CGADDR:  r = 8'h40 | (b & 8'h3f);
      MODE_DDADDR:  r = 8'h80 | (b & 8'h7f);
      MODE_WRDATA,
      MODE_RAW:     r = b;
      default:      r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/character_lcd_bus_controller.sv =====
// Top level of the character LCD bus controller: config registers and front/queue/back.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in_     | slave     | in_tvalid/in_tready  | tuser: mode; tdata: req_byte, bus_in
//  out_    | master    | out_tvalid/tready    | tuser: read_valid; tdata: pins + read_byte
//  cfg_    | slave     | cfg_valid/cfg_ready  | cfg_index, cfg_data (10 bits)
//
// One item is one time-base tick; the block takes one item per clock while the queue has room
// and returns one result per item. An accepted item is decoded, held in the two-entry queue
// and then popped by the sequencer step that loads the output register.
// Reset is synchronous, active low, and restores the default timing registers.
// An output stall backs up the queue; in_tready drops only when both entries are full.
// Configuration writes are always taken (cfg_ready is high).
module character_lcd_bus_controller #(
  parameter int COUNT_WIDTH = clbc_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] req_byte, [15:8] bus_in
  input  logic [3:0]  in_tuser,   // [3:0] mode
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [0] ready_res, [1] pin_rs, [2] pin_rw, [3] pin_e,
                                  // [11:4] bus_out, [12] bus_drive, [20:13] read_byte
  output logic        out_tuser,  // [0] read_valid
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [clbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [clbc_pkg::CFG_DATA_W-1:0] cfg_data
);

  clbc_pkg::cfg_t cfg_r, cfg_nxt;
  clbc_pkg::req_t front_req;
  clbc_pkg::req_t q_req;
  logic           q_not_full, q_not_empty, q_pop;
  logic           push;

  assign cfg_ready = 1'b1;
  assign in_tready = q_not_full;
  assign push      = in_tvalid && q_not_full;

  // register file; writes to unused indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        clbc_pkg::REG_FOUR_BIT:    cfg_nxt.four_bit    = cfg_data[0];
        clbc_pkg::REG_SETUP:       cfg_nxt.setup       = cfg_data;
        clbc_pkg::REG_ENABLE_HIGH: cfg_nxt.enable_high = cfg_data;
        clbc_pkg::REG_ENABLE_LOW:  cfg_nxt.enable_low  = cfg_data;
        clbc_pkg::REG_ADDR_INCR:   cfg_nxt.addr_incr   = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.four_bit    <= 1'b0;
      cfg_r.setup       <= clbc_pkg::SETUP_RST;
      cfg_r.enable_high <= clbc_pkg::ENABLE_HIGH_RST;
      cfg_r.enable_low  <= clbc_pkg::ENABLE_LOW_RST;
      cfg_r.addr_incr   <= clbc_pkg::ADDR_INCR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: decode mode and form the instruction byte
  clbc_front u_front (
    .mode     (in_tuser),
    .req_byte (in_tdata[7:0]),
    .bus_in   (in_tdata[15:8]),
    .req      (front_req)
  );

  // decouples the accept side from the sequencer and the output stall
  clbc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (front_req),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_req)
  );

  // back: phase sequencer (setup, E high, E low, address-increment wait)
  clbc_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_not_empty),
    .q_req     (q_req),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_flag  (out_tuser)
  );

endmodule

// ===== rtl/clbc_front.sv =====
// Front end: decodes an incoming tick item into a request descriptor.
module clbc_front (
  input  logic [3:0]    mode,
  input  logic [7:0]    req_byte,
  input  logic [7:0]    bus_in,
  output clbc_pkg::req_t req
);

  always_comb begin
    req.start   = (mode >= clbc_pkg::MODE_CLEAR) && (mode <= clbc_pkg::MODE_RAW);
    req.kind    = mode;
    req.pbyte   = clbc_pkg::form_byte(mode, req_byte);
    // raw instructions and address reads skip the busy poll
    req.polling = !((mode == clbc_pkg::MODE_RDADDR) || (mode == clbc_pkg::MODE_RAW));
    req.bus     = bus_in;
  end

endmodule

// ===== rtl/clbc_queue.sv =====
// Short FIFO of decoded items between front and back.
module clbc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  clbc_pkg::req_t push_data,
  output logic           not_full,
  input  logic           pop,
  output logic           not_empty,
  output clbc_pkg::req_t pop_data
);

  localparam int PTR_W = $clog2(clbc_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(clbc_pkg::QUEUE_DEPTH + 1);

  clbc_pkg::req_t   mem_r [clbc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;

  assign not_full  = (count_r != CNT_W'(clbc_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(clbc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(clbc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/clbc_back.sv =====
// Back end: bus-cycle sequencer advanced one tick per item, plus output register.
module clbc_back #(
  parameter int COUNT_WIDTH = clbc_pkg::COUNT_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  clbc_pkg::cfg_t cfg,
  input  logic           q_valid,
  input  clbc_pkg::req_t q_req,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [23:0]    out_data,
  output logic           out_flag
);

  localparam int CW    = COUNT_WIDTH;
  localparam int CMP_W = (CW > clbc_pkg::CFG_DATA_W) ? CW : clbc_pkg::CFG_DATA_W;
  localparam logic [CMP_W-1:0] CNT_MAX_EXT = CMP_W'((32'd1 << CW) - 32'd1);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_SETUP = 3'd1;
  localparam logic [2:0] PH_HIGH  = 3'd2;
  localparam logic [2:0] PH_LOW   = 3'd3;
  localparam logic [2:0] PH_WAIT  = 3'd4;

  function automatic logic [CW-1:0] sat(input logic [clbc_pkg::CFG_DATA_W-1:0] v);
    logic [CMP_W-1:0] ve;
    ve = CMP_W'(v);
    if (ve > CNT_MAX_EXT) ve = CNT_MAX_EXT;
    return CW'(ve);
  endfunction

  logic [2:0]    phase_r,  phase_nxt;
  logic [CW-1:0] tick_r,   tick_nxt;
  logic [3:0]    kind_r,   kind_nxt;
  logic [7:0]    pbyte_r,  pbyte_nxt;
  logic          second_r, second_nxt;
  logic [7:0]    accum_r,  accum_nxt;
  logic          poll_r,   poll_nxt;

  logic          out_valid_r;
  logic [23:0]   out_data_r, out_data_nxt;
  logic          out_flag_r, out_flag_nxt;

  logic [CW-1:0] d_setup, d_high, d_low, d_incr;
  logic [2:0]    cyc_phase;
  logic          rd_now, rd_new, active, rs, rw, pe, drive, rvalid;
  logic [7:0]    bout, rbyte;

  assign q_pop     = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_flag  = out_flag_r;

  always_comb begin
    d_setup = sat(cfg.setup);
    d_high  = sat((cfg.enable_high == '0) ? 10'd1 : cfg.enable_high);
    d_low   = sat((cfg.enable_low == '0) ? 10'd1 : cfg.enable_low);
    d_incr  = sat(cfg.addr_incr);
    cyc_phase = (d_setup == '0) ? PH_HIGH : PH_SETUP;
    rd_now = poll_r || (kind_r == clbc_pkg::MODE_RDADDR) || (kind_r == clbc_pkg::MODE_RDDATA);

    phase_nxt  = phase_r;
    tick_nxt   = tick_r;
    kind_nxt   = kind_r;
    pbyte_nxt  = pbyte_r;
    second_nxt = second_r;
    accum_nxt  = accum_r;
    poll_nxt   = poll_r;
    rvalid     = 1'b0;
    rbyte      = 8'h00;

    case (phase_r)
      PH_IDLE: begin
        if (q_req.start) begin
          kind_nxt   = q_req.kind;
          pbyte_nxt  = q_req.pbyte;
          poll_nxt   = q_req.polling;
          accum_nxt  = 8'h00;
          second_nxt = 1'b0;
          phase_nxt  = cyc_phase;
          tick_nxt   = CW'(1);
        end
      end
      PH_SETUP: begin
        if (tick_r >= d_setup) begin
          phase_nxt = PH_HIGH;
          tick_nxt  = CW'(1);
        end else begin
          tick_nxt = tick_r + 1'b1;
        end
      end
      PH_HIGH: begin
        if (tick_r >= d_high) begin
          // bus sampled on the tick E falls
          if (rd_now) begin
            if (!cfg.four_bit) begin
              accum_nxt = q_req.bus;
            end else if (!second_r) begin
              accum_nxt = {q_req.bus[3:0], 4'h0};
            end else begin
              accum_nxt = {accum_r[7:4], q_req.bus[3:0]};
            end
          end
          phase_nxt = PH_LOW;
          tick_nxt  = CW'(1);
        end else begin
          tick_nxt = tick_r + 1'b1;
        end
      end
      PH_LOW: begin
        if (tick_r >= d_low) begin
          if (cfg.four_bit && !second_r) begin
            second_nxt = 1'b1;
            phase_nxt  = PH_HIGH;
            tick_nxt   = CW'(1);
          end else if (poll_r) begin
            if (accum_r[7]) begin
              // still busy: poll again
              second_nxt = 1'b0;
              phase_nxt  = cyc_phase;
              tick_nxt   = CW'(1);
            end else begin
              poll_nxt   = 1'b0;
              second_nxt = 1'b0;
              tick_nxt   = CW'(1);
              if (((kind_r == clbc_pkg::MODE_WRDATA) || (kind_r == clbc_pkg::MODE_RDDATA))
                  && (d_incr != '0)) begin
                phase_nxt = PH_WAIT;
              end else begin
                phase_nxt = cyc_phase;
              end
            end
          end else begin
            if ((kind_r == clbc_pkg::MODE_RDADDR) || (kind_r == clbc_pkg::MODE_RDDATA)) begin
              rvalid = 1'b1;
              rbyte  = accum_r;
            end
            phase_nxt = PH_IDLE;
            tick_nxt  = '0;
          end
        end else begin
          tick_nxt = tick_r + 1'b1;
        end
      end
      PH_WAIT: begin
        if (tick_r >= d_incr) begin
          second_nxt = 1'b0;
          phase_nxt  = cyc_phase;
          tick_nxt   = CW'(1);
        end else begin
          tick_nxt = tick_r + 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        tick_nxt  = '0;
      end
    endcase

    // pin levels after this tick's update
    active = (phase_nxt == PH_SETUP) || (phase_nxt == PH_HIGH) || (phase_nxt == PH_LOW);
    rd_new = poll_nxt || (kind_nxt == clbc_pkg::MODE_RDADDR) ||
             (kind_nxt == clbc_pkg::MODE_RDDATA);
    rs     = active && !poll_nxt &&
             ((kind_nxt == clbc_pkg::MODE_WRDATA) || (kind_nxt == clbc_pkg::MODE_RDDATA));
    rw     = active && rd_new;
    pe     = (phase_nxt == PH_HIGH);
    drive  = !(active && rd_new);
    if (!active || rd_new) begin
      bout = 8'h00;
    end else if (!cfg.four_bit) begin
      bout = pbyte_nxt;
    end else if (second_nxt) begin
      bout = {4'h0, pbyte_nxt[3:0]};
    end else begin
      bout = {4'h0, pbyte_nxt[7:4]};
    end

    out_data_nxt = {3'b000, rbyte, drive, bout, pe, rw, rs, (phase_nxt == PH_IDLE)};
    out_flag_nxt = rvalid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      tick_r      <= '0;
      kind_r      <= '0;
      pbyte_r     <= '0;
      second_r    <= 1'b0;
      accum_r     <= '0;
      poll_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r  <= phase_nxt;
        tick_r   <= tick_nxt;
        kind_r   <= kind_nxt;
        pbyte_r  <= pbyte_nxt;
        second_r <= second_nxt;
        accum_r  <= accum_nxt;
        poll_r   <= poll_nxt;
      end
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= out_data_nxt;
      out_flag_r <= out_flag_nxt;
    end
  end

endmodule

// ===== tb/tb.sv =====
// Testbench for the character LCD bus controller: one item per tick, pins predicted per tick.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT hookup
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = 16'h0000;  // [7:0] req_byte, [15:8] bus_in
  logic [3:0]  in_tuser = 4'h0;      // [3:0] mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;            // [0] ready_res, [1] rs, [2] rw, [3] e,
                                     // [11:4] bus_out, [12] bus_drive, [20:13] read_byte
  logic        out_tuser;            // [0] read_valid
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [clbc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [clbc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  character_lcd_bus_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Types
  // ---------------------------------------------------------------------------
  // one host tick: optional request plus the LCD pins seen this tick
  typedef struct {
    logic [3:0] mode;
    logic [7:0] req;
    logic [7:0] bus;
  } host_tick_t;

  // pin levels and read return after one tick
  typedef struct packed {
    logic       ready;
    logic       rs;
    logic       rw;
    logic       e;
    logic [7:0] bus_out;
    logic       drive;
    logic       rvalid;
    logic [7:0] rbyte;
  } pin_levels_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SETUP, ST_E_HIGH, ST_E_LOW, ST_INCR_WAIT
  } bus_phase_t;

  // ---------------------------------------------------------------------------
  // Scoreboard storage and counters
  // ---------------------------------------------------------------------------
  host_tick_t  host_ticks[$];     // ticks waiting to be driven
  pin_levels_t pin_levels_q[$];   // predicted pin levels, oldest first
  int          ticks_queued = 0;
  int          ticks_taken  = 0;
  int          mismatches   = 0;

  // shadow timing registers, reset values
  logic       cfg_nibble = 1'b0;
  logic [9:0] cfg_setup  = clbc_pkg::SETUP_RST;
  logic [9:0] cfg_high   = clbc_pkg::ENABLE_HIGH_RST;
  logic [9:0] cfg_low    = clbc_pkg::ENABLE_LOW_RST;
  logic [9:0] cfg_incr   = clbc_pkg::ADDR_INCR_RST;

  // predictor state
  bus_phase_t seq       = ST_IDLE;
  int         ticks     = 0;
  logic [3:0] op_kind   = clbc_pkg::MODE_TICK;
  logic [7:0] op_byte   = 8'h00;
  logic       low_half  = 1'b0;   // second nibble of a 4-bit transfer
  logic [7:0] rd_accum  = 8'h00;
  logic       poll_busy = 1'b0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  // Instruction byte: one command bit plus kept parameter bits; data and raw pass as is.
  function automatic logic [7:0] instr_byte(input logic [3:0] kind, input logic [7:0] b);
    case (kind)
      clbc_pkg::MODE_CLEAR:   return 8'h01;
      clbc_pkg::MODE_HOME:    return 8'h02;
      clbc_pkg::MODE_ENTRY:   return 8'h04 | (b & 8'h03);
      clbc_pkg::MODE_ONOFF:   return 8'h08 | (b & 8'h07);
      clbc_pkg::MODE_SHIFT:   return 8'h10 | (b & 8'h0c);  // S/C, R/L
      clbc_pkg::MODE_FUNCSET: return 8'h20 | (b & 8'h1c);  // DL, N, F
      clbc_pkg::MODE_CGADDR:  return 8'h40 | (b & 8'h3f);
      clbc_pkg::MODE_DDADDR:  return 8'h80 | (b & 8'h7f);
      clbc_pkg::MODE_WRDATA, clbc_pkg::MODE_RAW: return b;
      default:                return 8'h00;
    endcase
  endfunction

  // Zero enable times count as one tick. Registers are as wide as the counter,
  // so saturation never applies at the default width.
  function automatic int span(input logic [9:0] v, input logic at_least_one);
    int r;
    r = int'(v);
    if (at_least_one && r == 0) r = 1;
    return r;
  endfunction

  function automatic logic bus_reads();
    return poll_busy || op_kind == clbc_pkg::MODE_RDADDR || op_kind == clbc_pkg::MODE_RDDATA;
  endfunction

  task automatic begin_bus_cycle();
    low_half = 1'b0;
    ticks    = 1;
    seq      = (cfg_setup == 0) ? ST_E_HIGH : ST_SETUP;
  endtask

  task automatic lcd_bus_step(input logic [3:0] mode, input logic [7:0] req,
                              input logic [7:0] bus, output pin_levels_t lv);
    logic reading;
    lv = '0;
    lv.drive = 1'b1;
    case (seq)
      ST_IDLE: begin
        if (mode >= clbc_pkg::MODE_CLEAR && mode <= clbc_pkg::MODE_RAW) begin
          op_kind   = mode;
          op_byte   = instr_byte(mode, req);
          // raw instructions and address reads skip the busy poll
          poll_busy = !(mode == clbc_pkg::MODE_RDADDR || mode == clbc_pkg::MODE_RAW);
          rd_accum  = 8'h00;
          begin_bus_cycle();
        end
      end
      ST_SETUP: begin
        if (ticks >= span(cfg_setup, 1'b0)) begin
          seq   = ST_E_HIGH;
          ticks = 1;
        end else ticks++;
      end
      ST_E_HIGH: begin
        if (ticks >= span(cfg_high, 1'b1)) begin
          // pins are taken on the tick E falls
          if (bus_reads()) begin
            if (!cfg_nibble) rd_accum = bus;
            else if (!low_half) rd_accum = {bus[3:0], 4'h0};
            else rd_accum = {rd_accum[7:4], bus[3:0]};
          end
          seq   = ST_E_LOW;
          ticks = 1;
        end else ticks++;
      end
      ST_E_LOW: begin
        if (ticks >= span(cfg_low, 1'b1)) begin
          if (cfg_nibble && !low_half) begin
            // second nibble follows with no new setup
            low_half = 1'b1;
            seq      = ST_E_HIGH;
            ticks    = 1;
          end else if (poll_busy) begin
            if (rd_accum[7]) begin_bus_cycle();
            else begin
              poll_busy = 1'b0;
              if ((op_kind == clbc_pkg::MODE_WRDATA || op_kind == clbc_pkg::MODE_RDDATA)
                  && cfg_incr != 0) begin
                seq   = ST_INCR_WAIT;
                ticks = 1;
              end else begin_bus_cycle();
            end
          end else begin
            if (op_kind == clbc_pkg::MODE_RDADDR || op_kind == clbc_pkg::MODE_RDDATA) begin
              lv.rvalid = 1'b1;
              lv.rbyte  = rd_accum;
            end
            seq   = ST_IDLE;
            ticks = 0;
          end
        end else ticks++;
      end
      ST_INCR_WAIT: begin
        if (ticks >= span(cfg_incr, 1'b0)) begin_bus_cycle();
        else ticks++;
      end
      default: begin
        seq   = ST_IDLE;
        ticks = 0;
      end
    endcase

    if (seq == ST_SETUP || seq == ST_E_HIGH || seq == ST_E_LOW) begin
      reading = bus_reads();
      lv.rs = !poll_busy &&
              (op_kind == clbc_pkg::MODE_WRDATA || op_kind == clbc_pkg::MODE_RDDATA);
      lv.rw = reading;
      lv.e  = (seq == ST_E_HIGH);
      if (reading) begin
        lv.drive   = 1'b0;
        lv.bus_out = 8'h00;
      end else if (!cfg_nibble) lv.bus_out = op_byte;
      else lv.bus_out = low_half ? {4'h0, op_byte[3:0]} : {4'h0, op_byte[7:4]};
    end
    lv.ready = (seq == ST_IDLE);
  endtask

  // ---------------------------------------------------------------------------
  // Idle pattern: mostly short gaps, a few long ones, and calm stretches with none
  // ---------------------------------------------------------------------------
  function automatic int pick_idle(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      calm_left = $urandom_range(30, 150);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: one tick per handshake, random gaps between items
  // ---------------------------------------------------------------------------
  int         in_hold = 0;
  int         in_calm = 0;
  host_tick_t next_tick;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_hold > 0) begin
        in_hold--;
        in_tvalid <= 1'b0;
      end else if (host_ticks.size() != 0) begin
        next_tick = host_ticks.pop_front();
        in_tuser  <= next_tick.mode;
        in_tdata  <= {next_tick.bus, next_tick.req};
        in_tvalid <= 1'b1;
        in_hold   = pick_idle(in_calm);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Every accepted tick advances the predictor by one step.
  pin_levels_t predicted;

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      lcd_bus_step(in_tuser, in_tdata[7:0], in_tdata[15:8], predicted);
      pin_levels_q.push_back(predicted);
      ticks_taken++;
    end
  end

  // Register writes go straight into the shadow copy.
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        clbc_pkg::REG_FOUR_BIT:    cfg_nibble = cfg_data[0];
        clbc_pkg::REG_SETUP:       cfg_setup  = cfg_data;
        clbc_pkg::REG_ENABLE_HIGH: cfg_high   = cfg_data;
        clbc_pkg::REG_ENABLE_LOW:  cfg_low    = cfg_data;
        clbc_pkg::REG_ADDR_INCR:   cfg_incr   = cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and per-field compare
  // ---------------------------------------------------------------------------
  int out_hold = 0;
  int out_calm = 0;

  always @(posedge clk) begin
    if (out_hold > 0) begin
      out_tready <= 1'b0;
      out_hold--;
    end else begin
      out_tready <= 1'b1;
      out_hold = pick_idle(out_calm);
    end
  end

  task automatic report(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 50)
      $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  pin_levels_t want_lv;
  pin_levels_t got_lv;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pin_levels_q.size() == 0) begin
        report("result with no prediction pending", int'(out_tdata), 0);
      end else begin
        want_lv = pin_levels_q.pop_front();
        got_lv  = '{ready: out_tdata[0], rs: out_tdata[1], rw: out_tdata[2],
                    e: out_tdata[3], bus_out: out_tdata[11:4], drive: out_tdata[12],
                    rvalid: out_tuser, rbyte: out_tdata[20:13]};
        if (got_lv.ready !== want_lv.ready)
          report("ready_res", int'(got_lv.ready), int'(want_lv.ready));
        if (got_lv.rs !== want_lv.rs)
          report("pin_rs", int'(got_lv.rs), int'(want_lv.rs));
        if (got_lv.rw !== want_lv.rw)
          report("pin_rw", int'(got_lv.rw), int'(want_lv.rw));
        if (got_lv.e !== want_lv.e)
          report("pin_e", int'(got_lv.e), int'(want_lv.e));
        if (got_lv.bus_out !== want_lv.bus_out)
          report("bus_out", int'(got_lv.bus_out), int'(want_lv.bus_out));
        if (got_lv.drive !== want_lv.drive)
          report("bus_drive", int'(got_lv.drive), int'(want_lv.drive));
        if (got_lv.rvalid !== want_lv.rvalid)
          report("read_valid", int'(got_lv.rvalid), int'(want_lv.rvalid));
        if (got_lv.rbyte !== want_lv.rbyte)
          report("read_byte", int'(got_lv.rbyte), int'(want_lv.rbyte));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_tick(input logic [3:0] mode, input logic [7:0] req,
                           input logic [7:0] bus);
    host_tick_t t;
    t.mode = mode;
    t.req  = req;
    t.bus  = bus;
    host_ticks.push_back(t);
    ticks_queued++;
  endtask

  // a request followed by plain ticks showing the same pins
  task automatic queue_request(input logic [3:0] mode, input logic [7:0] req,
                               input logic [7:0] bus, input int trailing);
    push_tick(mode, req, bus);
    repeat (trailing) push_tick(clbc_pkg::MODE_TICK, 8'h00, bus);
  endtask

  // Random ticks. Most pins show busy clear so polls finish and whole
  // transfers complete; the rest keep the poll loop going.
  task automatic queue_random(input int n);
    int         r;
    logic [3:0] md;
    logic [7:0] pins;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 45) md = clbc_pkg::MODE_TICK;
      else if (r < 92) md = 4'($urandom_range(clbc_pkg::MODE_CLEAR, clbc_pkg::MODE_RAW));
      else md = 4'($urandom_range(13, 15));  // unused modes
      pins = 8'($urandom);
      if ($urandom_range(0, 9) < 7) begin
        pins[7] = 1'b0;  // busy bit in 8-bit mode
        pins[3] = 1'b0;  // busy bit as seen in the high nibble in 4-bit mode
      end
      push_tick(md, 8'($urandom), pins);
    end
  endtask

  // wait until every queued tick is taken and every result is checked
  task automatic settle();
    @(posedge clk);
    while (host_ticks.size() != 0 || ticks_taken != ticks_queued || pin_levels_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic cfg_write(input logic [clbc_pkg::CFG_IDX_W-1:0] idx, input logic [9:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_timing(input logic four, input logic [9:0] setup, input logic [9:0] high,
                             input logic [9:0] low, input logic [9:0] incr);
    @(posedge clk);
    cfg_write(clbc_pkg::REG_FOUR_BIT, {9'd0, four});
    cfg_write(clbc_pkg::REG_SETUP, setup);
    cfg_write(clbc_pkg::REG_ENABLE_HIGH, high);
    cfg_write(clbc_pkg::REG_ENABLE_LOW, low);
    cfg_write(clbc_pkg::REG_ADDR_INCR, incr);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int m;
    int ph;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset timing: a data read polls, waits the address increment, then reads.
    queue_request(clbc_pkg::MODE_RDDATA, 8'h00, 8'h5a, 340);
    settle();

    // Shortest timing, 8-bit bus: every request mode from clear up, the byte all ones for odd
    // modes and all zeros for even ones, unused modes included.
    load_timing(1'b0, 10'd0, 10'd0, 10'd0, 10'd0);
    for (m = 1; m < 16; m++)
      queue_request(m[3:0], m[0] ? 8'hff : 8'h00, m[1] ? 8'h7f : 8'h00, 10);
    // address read returns the busy bit as read, no poll in front
    queue_request(clbc_pkg::MODE_RDADDR, 8'h00, 8'hff, 10);
    // busy held for a few polls, then released
    queue_request(clbc_pkg::MODE_CLEAR, 8'h00, 8'h80, 6);
    queue_request(clbc_pkg::MODE_TICK, 8'h00, 8'h00, 60);
    settle();

    // Random phases; each ends with quiet ticks so the bus cycle in flight finishes.
    for (ph = 0; ph < 4; ph++) begin
      if (ph == 0) load_timing(1'b1, 10'd1, 10'd2, 10'd1, 10'd3);
      else if (ph == 1) load_timing(1'b1, 10'd7, 10'd12, 10'd9, 10'd30);
      else load_timing(1'($urandom_range(0, 1)), 10'($urandom_range(0, 4)),
                       10'($urandom_range(0, 4)), 10'($urandom_range(0, 4)),
                       10'($urandom_range(0, 6)));
      queue_random(140);
      queue_request(clbc_pkg::MODE_TICK, 8'h00, 8'h00, 179);
      settle();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("[character_lcd_bus_controller] OK");
    end else begin
      $display("[character_lcd_bus_controller] ERROR");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #50_000_000;
    $display("[character_lcd_bus_controller] ERROR");
    $finish;
  end

endmodule
